### hw/rtl/ahog_pkg.sv
package ahog_pkg;

    parameter int VALUE_WIDTH = 32;

    localparam int CMP_W    = (VALUE_WIDTH + 1 > 32) ? VALUE_WIDTH + 1 : 32;
    localparam int CFG_DW   = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
    localparam int CFG_IW   = 4;
    localparam int HYST_W   = 31;
    localparam int DBAND_W  = 32;
    localparam int MODE_W   = 16;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [2:0] t_status;
    typedef logic [1:0] t_sev;
    typedef logic [2:0] t_trig;
    typedef logic [1:0] t_action;
    typedef logic [CFG_IW-1:0] t_cfg_idx;

    // register indexes
    localparam t_cfg_idx CFG_LIMIT_HIHI  = 4'd0;
    localparam t_cfg_idx CFG_LIMIT_HIGH  = 4'd1;
    localparam t_cfg_idx CFG_LIMIT_LOW   = 4'd2;
    localparam t_cfg_idx CFG_LIMIT_LOLO  = 4'd3;
    localparam t_cfg_idx CFG_HYSTERESIS  = 4'd4;
    localparam t_cfg_idx CFG_DEADBAND    = 4'd5;
    localparam t_cfg_idx CFG_INVALID_OUT = 4'd6;
    localparam t_cfg_idx CFG_MODE_BITS   = 4'd7;

    // alarm status codes
    localparam t_status ST_NONE = 3'd0;
    localparam t_status ST_CALC = 3'd1;
    localparam t_status ST_UDF  = 3'd2;
    localparam t_status ST_HIHI = 3'd3;
    localparam t_status ST_LOLO = 3'd4;
    localparam t_status ST_HIGH = 3'd5;
    localparam t_status ST_LOW  = 3'd6;

    // alarm severity codes
    localparam t_sev SEV_NONE    = 2'd0;
    localparam t_sev SEV_MINOR   = 2'd1;
    localparam t_sev SEV_MAJOR   = 2'd2;
    localparam t_sev SEV_INVALID = 2'd3;

    // trigger modes; codes above TRIG_RISE never drive
    localparam t_trig TRIG_ALWAYS  = 3'd0;
    localparam t_trig TRIG_CHANGE  = 3'd1;
    localparam t_trig TRIG_ZERO    = 3'd2;
    localparam t_trig TRIG_NONZERO = 3'd3;
    localparam t_trig TRIG_FALL    = 3'd4;
    localparam t_trig TRIG_RISE    = 3'd5;

    // invalid-output actions
    localparam t_action ACT_WRITE     = 2'd0;
    localparam t_action ACT_SKIP      = 2'd1;
    localparam t_action ACT_WRITE_INV = 2'd2;
    localparam t_action ACT_SKIP_ALT  = 2'd3;

    // mode_bits field positions
    localparam int MB_SEV_HIHI = 0;
    localparam int MB_SEV_HIGH = 2;
    localparam int MB_SEV_LOW  = 4;
    localparam int MB_SEV_LOLO = 6;
    localparam int MB_TRIG     = 8;
    localparam int MB_USE_ALT  = 11;
    localparam int MB_ACTION   = 12;

    typedef struct packed {
        t_value                    limit_hihi;
        t_value                    limit_high;
        t_value                    limit_low;
        t_value                    limit_lolo;
        logic [HYST_W-1:0]         hysteresis;
        logic signed [DBAND_W-1:0] deadband;
        t_value                    invalid_out;
        logic [MODE_W-1:0]         mode_bits;
    } t_cfg;

    typedef struct packed {
        t_value sample;
        logic   sample_failed;
        logic   sample_nan;
        t_value alt_sample;
        logic   alt_failed;
        logic   alt_nan;
    } t_item;

    typedef struct packed {
        t_value  value_out;
        t_status alarm_status;
        t_sev    alarm_severity;
        logic    drive_output;
        t_value  drive_value;
        logic    post_monitor;
    } t_result;

    typedef struct packed {
        t_value  held;
        t_value  prev;
        t_value  alarm_lvl;
        t_value  monitored;
        logic    udf;
        t_status status;
        t_sev    sev;
        t_value  last_out;
    } t_state;

endpackage

### hw/rtl/ahog_in_if.sv
interface ahog_in_if import ahog_pkg::*;;
    logic   valid;
    logic   ready;
    t_value sample;
    logic   sample_failed;
    logic   sample_nan;
    t_value alt_sample;
    logic   alt_failed;
    logic   alt_nan;

    modport source (
        output valid, sample, sample_failed, sample_nan, alt_sample, alt_failed, alt_nan,
        input  ready
    );
    modport sink (
        input  valid, sample, sample_failed, sample_nan, alt_sample, alt_failed, alt_nan,
        output ready
    );
endinterface

### hw/rtl/ahog_out_if.sv
interface ahog_out_if import ahog_pkg::*;;
    logic    valid;
    logic    ready;
    t_value  value_out;
    t_status alarm_status;
    t_sev    alarm_severity;
    logic    drive_output;
    t_value  drive_value;
    logic    post_monitor;

    modport source (
        output valid, value_out, alarm_status, alarm_severity, drive_output, drive_value,
               post_monitor,
        input  ready
    );
    modport sink (
        input  valid, value_out, alarm_status, alarm_severity, drive_output, drive_value,
               post_monitor,
        output ready
    );
endinterface

### hw/rtl/ahog_cfg_if.sv
interface ahog_cfg_if import ahog_pkg::*;;
    logic              valid;
    logic              ready;
    t_cfg_idx          index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/ahog_cfg_regs.sv
module ahog_cfg_regs import ahog_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ahog_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LIMIT_HIHI:  r_cfg.limit_hihi  <= i_cfg.data[VALUE_WIDTH-1:0];
                CFG_LIMIT_HIGH:  r_cfg.limit_high  <= i_cfg.data[VALUE_WIDTH-1:0];
                CFG_LIMIT_LOW:   r_cfg.limit_low   <= i_cfg.data[VALUE_WIDTH-1:0];
                CFG_LIMIT_LOLO:  r_cfg.limit_lolo  <= i_cfg.data[VALUE_WIDTH-1:0];
                CFG_HYSTERESIS:  r_cfg.hysteresis  <= i_cfg.data[HYST_W-1:0];
                CFG_DEADBAND:    r_cfg.deadband    <= i_cfg.data[DBAND_W-1:0];
                CFG_INVALID_OUT: r_cfg.invalid_out <= i_cfg.data[VALUE_WIDTH-1:0];
                CFG_MODE_BITS:   r_cfg.mode_bits   <= i_cfg.data[MODE_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

endmodule

### hw/rtl/ahog_eval.sv
module ahog_eval import ahog_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    // v at or above lim, or still inside the release band of the last alarmed limit
    function automatic logic f_above(t_value v, t_value lim, t_value lvl,
                                     logic [HYST_W-1:0] hyst);
        logic [VALUE_WIDTH:0] diff;
        diff = {lim[VALUE_WIDTH-1], lim} - {v[VALUE_WIDTH-1], v};
        return (v >= lim) || ((lvl == lim) && (CMP_W'(diff) <= CMP_W'(hyst)));
    endfunction

    function automatic logic f_below(t_value v, t_value lim, t_value lvl,
                                     logic [HYST_W-1:0] hyst);
        logic [VALUE_WIDTH:0] diff;
        diff = {v[VALUE_WIDTH-1], v} - {lim[VALUE_WIDTH-1], lim};
        return (v <= lim) || ((lvl == lim) && (CMP_W'(diff) <= CMP_W'(hyst)));
    endfunction

    // |a - b| <= d; a negative deadband never matches
    function automatic logic f_within(t_value a, t_value b, logic signed [DBAND_W-1:0] d);
        logic [VALUE_WIDTH:0] diff;
        if (a >= b) begin
            diff = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        end else begin
            diff = {b[VALUE_WIDTH-1], b} - {a[VALUE_WIDTH-1], a};
        end
        return !d[DBAND_W-1] && (CMP_W'(diff) <= CMP_W'($unsigned(d)));
    endfunction

    t_value  v;
    t_sev    sev_hihi, sev_high, sev_low, sev_lolo;
    logic    hit_hihi, hit_high, hit_low, hit_lolo;
    logic    prev_within, mon_within;
    t_trig   trig;
    t_action action;
    t_status status;
    t_sev    sev;
    logic    drive;
    logic    post;

    assign v        = i_item.sample_failed ? i_state.held : i_item.sample;
    assign sev_hihi = i_cfg.mode_bits[MB_SEV_HIHI +: 2];
    assign sev_high = i_cfg.mode_bits[MB_SEV_HIGH +: 2];
    assign sev_low  = i_cfg.mode_bits[MB_SEV_LOW  +: 2];
    assign sev_lolo = i_cfg.mode_bits[MB_SEV_LOLO +: 2];
    assign trig     = i_cfg.mode_bits[MB_TRIG +: 3];
    assign action   = i_cfg.mode_bits[MB_ACTION +: 2];

    assign hit_hihi = (sev_hihi != SEV_NONE) &&
        f_above(v, i_cfg.limit_hihi, i_state.alarm_lvl, i_cfg.hysteresis);
    assign hit_lolo = (sev_lolo != SEV_NONE) &&
        f_below(v, i_cfg.limit_lolo, i_state.alarm_lvl, i_cfg.hysteresis);
    assign hit_high = (sev_high != SEV_NONE) &&
        f_above(v, i_cfg.limit_high, i_state.alarm_lvl, i_cfg.hysteresis);
    assign hit_low  = (sev_low != SEV_NONE) &&
        f_below(v, i_cfg.limit_low, i_state.alarm_lvl, i_cfg.hysteresis);

    assign prev_within = f_within(i_state.prev, v, i_cfg.deadband);
    assign mon_within  = f_within(i_state.monitored, v, i_cfg.deadband);

    always_comb begin
        o_state = i_state;
        status  = ST_NONE;
        sev     = SEV_NONE;
        drive   = 1'b0;

        // take the sample unless its calculation failed
        if (i_item.sample_failed) begin
            status = ST_CALC;
            sev    = SEV_INVALID;
        end else begin
            o_state.held = i_item.sample;
            o_state.udf  = i_item.sample_nan;
        end

        // undefined, then limits in priority order; a hit that cannot raise still ends the chain
        if (o_state.udf) begin
            if (sev < SEV_INVALID) begin
                status = ST_UDF;
                sev    = SEV_INVALID;
            end
        end else if (hit_hihi) begin
            if (sev_hihi > sev) begin
                status            = ST_HIHI;
                sev               = sev_hihi;
                o_state.alarm_lvl = i_cfg.limit_hihi;
            end
        end else if (hit_lolo) begin
            if (sev_lolo > sev) begin
                status            = ST_LOLO;
                sev               = sev_lolo;
                o_state.alarm_lvl = i_cfg.limit_lolo;
            end
        end else if (hit_high) begin
            if (sev_high > sev) begin
                status            = ST_HIGH;
                sev               = sev_high;
                o_state.alarm_lvl = i_cfg.limit_high;
            end
        end else if (hit_low) begin
            if (sev_low > sev) begin
                status            = ST_LOW;
                sev               = sev_low;
                o_state.alarm_lvl = i_cfg.limit_low;
            end
        end else begin
            o_state.alarm_lvl = v;
        end

        case (trig)
            TRIG_ALWAYS:  drive = 1'b1;
            TRIG_CHANGE:  drive = !prev_within;
            TRIG_ZERO:    drive = (v == '0);
            TRIG_NONZERO: drive = (v != '0);
            TRIG_FALL:    drive = (i_state.prev != '0) && (v == '0);
            TRIG_RISE:    drive = (i_state.prev == '0) && (v != '0);
            default:      drive = 1'b0;
        endcase
        o_state.prev = v;

        if (drive) begin
            if (i_cfg.mode_bits[MB_USE_ALT]) begin
                if (i_item.alt_failed) begin
                    if (sev < SEV_INVALID) begin
                        status = ST_CALC;
                        sev    = SEV_INVALID;
                    end
                end else begin
                    o_state.last_out = i_item.alt_sample;
                    o_state.udf      = i_item.alt_nan;
                end
            end else begin
                o_state.last_out = v;
            end
            if (o_state.udf && (sev < SEV_INVALID)) begin
                status = ST_UDF;
                sev    = SEV_INVALID;
            end
            if (sev == SEV_INVALID) begin
                case (action)
                    ACT_WRITE:     drive = 1'b1;
                    ACT_WRITE_INV: o_state.last_out = i_cfg.invalid_out;
                    default:       drive = 1'b0;
                endcase
            end
        end

        post           = (status != i_state.status) || (sev != i_state.sev);
        o_state.status = status;
        o_state.sev    = sev;
        if (!mon_within) begin
            post              = 1'b1;
            o_state.monitored = v;
        end

        o_result.value_out      = v;
        o_result.alarm_status   = status;
        o_result.alarm_severity = sev;
        o_result.drive_output   = drive;
        o_result.drive_value    = drive ? o_state.last_out : '0;
        o_result.post_monitor   = post;
    end

endmodule

### hw/rtl/alarm_hysteresis_output_gate_top.sv
// Four-level alarm checker with hysteresis and a gated output value. Each input
// beat carries one signed Q16.16 sample with failure and not-a-number flags plus an
// optional second value; each accepted beat yields exactly one result beat with the
// stored value, the alarm status and severity, the output-drive decision and value,
// and a monitor-post flag. Throughput is one beat per clock unless output stalls:
// the sample sits in an input register, one pass of compare and subtract logic
// against the limit, hysteresis and deadband registers produces both the result and
// the next state, and both land in registers on the same edge, so every result
// depends on all earlier samples in order. A beat passes through the input register,
// then the output register; the two let a new beat in while a finished result still
// waits on the output. Configuration registers are written through the config
// channel, which is always ready; write them only while no beat is in flight.
module alarm_hysteresis_output_gate_top import ahog_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ahog_in_if.sink   i_in,
    ahog_out_if.source o_out,
    ahog_cfg_if.sink  i_cfg
);

    t_cfg    cfg;
    t_item   in_item;
    t_state  n_state;
    t_result n_result;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    logic    advance;
    logic    in_ready;

    ahog_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ahog_eval u_eval (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign in_item = '{
        sample:        i_in.sample,
        sample_failed: i_in.sample_failed,
        sample_nan:    i_in.sample_nan,
        alt_sample:    i_in.alt_sample,
        alt_failed:    i_in.alt_failed,
        alt_nan:       i_in.alt_nan
    };

    // advance the held beat whenever the output slot is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready   = !r_in_valid || advance;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in <= in_item;
        end
    end

    // state moves only when a result is committed to the output register;
    // the value starts out undefined
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{udf: 1'b1, default: '0};
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.value_out      = r_out.value_out;
    assign o_out.alarm_status   = r_out.alarm_status;
    assign o_out.alarm_severity = r_out.alarm_severity;
    assign o_out.drive_output   = r_out.drive_output;
    assign o_out.drive_value    = r_out.drive_value;
    assign o_out.post_monitor   = r_out.post_monitor;

endmodule
